FILE: rtl/rsvp_pkg.sv
// Shared types, register map and square-root step for the vertex ray picker.
package rsvp_pkg;

  localparam int MAX_VERTICES = 65536;

  localparam int AddrW = 5;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DIR_X = 3'd3;
  localparam logic [RegIdxW-1:0] REG_DIR_Y = 3'd4;
  localparam logic [RegIdxW-1:0] REG_DIR_Z = 3'd5;
  localparam logic [RegIdxW-1:0] REG_PICK_RADIUS = 3'd6;

  localparam int SqrtInW = 50;
  localparam int SqrtOutW = 25;
  localparam int SqrtRemW = 28;
  localparam int SqrtStages = 5;
  localparam int SqrtStepsPerStage = 5;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic signed [23:0] vertex_z;
    logic               last_vertex;
  } vtx_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] vertex_index;
    logic [25:0] distance;
    logic        any_hit;
    logic        pass_end;
  } res_t;

  typedef struct packed {
    logic [SqrtRemW-1:0] rem;
    logic [SqrtOutW-1:0] root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] bits);
    sqrt_st_t            r;
    logic [SqrtRemW-1:0] rem;
    logic [SqrtRemW-1:0] trial;
    rem = {s.rem[SqrtRemW-3:0], bits};
    trial = {1'b0, s.root, 2'b01};
    if (rem >= trial) begin
      r.rem = rem - trial;
      r.root = {s.root[SqrtOutW-2:0], 1'b1};
    end else begin
      r.rem = rem;
      r.root = {s.root[SqrtOutW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/rsvp_sqrt.sv
// Pipelined integer square root, five result bits per stage.
module rsvp_sqrt import rsvp_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SqrtInW-1:0]  x_i,
  output logic [SqrtOutW-1:0] root_o
);

  sqrt_st_t           st_q [SqrtStages];
  logic [SqrtInW-1:0] x_q  [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    sqrt_st_t           st_src;
    sqrt_st_t           st_d;
    logic [SqrtInW-1:0] x_src;

    if (k == 0) begin : g_first
      assign st_src = '0;
      assign x_src = x_i;
    end else begin : g_next
      assign st_src = st_q[k-1];
      assign x_src = x_q[k-1];
    end

    always_comb begin
      sqrt_st_t s;
      s = st_src;
      for (int j = 0; j < SqrtStepsPerStage; j++) begin
        s = sqrt_step(s, x_src[2*(SqrtOutW-1-(k*SqrtStepsPerStage+j)) +: 2]);
      end
      st_d = s;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
        x_q[k] <= x_src;
      end
    end
  end

  assign root_o = st_q[SqrtStages-1].root;

endmodule

FILE: rtl/ray_sphere_vertex_pick.sv
// Top level of the vertex ray picker: registers, discriminant pipeline and output.
//
//   channel   | direction | handshake              | beat
//   in        | in        | in_valid_i / in_stall_o | vtx_t vertex
//   out       | out       | out_valid_o / out_stall_i | res_t result
//   config    | in        | APB psel/penable       | one register
//
// One vertex enters per cycle while the output is not stalled.
// Its result passes through the split wide products and the five-stage square root.
// Reset clears the pass counter, the hit flag and the registers, but sets the Z direction to 65536.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
module ray_sphere_vertex_pick import rsvp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vtx_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic signed [23:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
  logic [22:0]        rad_q;
  logic [RegIdxW-1:0] widx;

  assign pready = 1'b1;
  assign widx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
      dx_q <= '0;
      dy_q <= '0;
      dz_q <= 24'sd65536;
      rad_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_ORIGIN_X:    ox_q <= pwdata[23:0];
        REG_ORIGIN_Y:    oy_q <= pwdata[23:0];
        REG_ORIGIN_Z:    oz_q <= pwdata[23:0];
        REG_DIR_X:       dx_q <= pwdata[23:0];
        REG_DIR_Y:       dy_q <= pwdata[23:0];
        REG_DIR_Z:       dz_q <= pwdata[23:0];
        REG_PICK_RADIUS: rad_q <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ORIGIN_X:    prdata = {8'b0, ox_q};
      REG_ORIGIN_Y:    prdata = {8'b0, oy_q};
      REG_ORIGIN_Z:    prdata = {8'b0, oz_q};
      REG_DIR_X:       prdata = {8'b0, dx_q};
      REG_DIR_Y:       prdata = {8'b0, dy_q};
      REG_DIR_Z:       prdata = {8'b0, dz_q};
      REG_PICK_RADIUS: prdata = {9'b0, rad_q};
      default:         prdata = '0;
    endcase
  end

  logic       en;
  logic       in_acc;
  logic [8:0] v_q;

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc = in_valid_i && en;

  logic [15:0] cnt_q;
  logic        seen_q;
  logic [16:0] cnt_inc;

  assign cnt_inc = {1'b0, cnt_q} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      if (in_data_i.last_vertex || 32'(cnt_inc) >= MAX_VERTICES) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[7:0], in_valid_i};
    end
  end

  logic [15:0] idx_q [8];
  logic [7:0]  last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q[0] <= cnt_q;
      last_q[0] <= in_data_i.last_vertex;
      for (int i = 1; i < 8; i++) begin
        idx_q[i] <= idx_q[i-1];
        last_q[i] <= last_q[i-1];
      end
    end
  end

  logic signed [24:0] rx_q, ry_q, rz_q;
  logic signed [48:0] prx_q, pry_q, prz_q;
  logic [48:0]        sqx_q, sqy_q, sqz_q;
  logic [46:0]        ddx_q, ddy_q, ddz_q;
  logic [45:0]        rr2_q, rr3_q;
  logic signed [50:0] dro_q;
  logic [48:0]        dd3_q, dd4_q;
  logic [49:0]        roro_q;
  logic signed [50:0] c_q;
  logic [50:0]        p_q;
  logic               cpos_q;
  logic [51:0]        pll_q, qll_q;
  logic [50:0]        plh_q;
  logic [49:0]        phh_q, qlh_q;
  logic [48:0]        qhl_q;
  logic [46:0]        qhh_q;
  logic               cpos6_q;
  logic [101:0]       lhs_q, rhs_q;
  logic               hit7_q, hit8_q;
  logic signed [49:0] sx, sy, sz;
  logic signed [46:0] qx, qy, qz;
  logic [49:0]        cu;

  assign sx = rx_q * rx_q;
  assign sy = ry_q * ry_q;
  assign sz = rz_q * rz_q;
  assign qx = dx_q * dx_q;
  assign qy = dy_q * dy_q;
  assign qz = dz_q * dz_q;
  assign cu = c_q[49:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q <= {in_data_i.vertex_x[23], in_data_i.vertex_x} - {ox_q[23], ox_q};
      ry_q <= {in_data_i.vertex_y[23], in_data_i.vertex_y} - {oy_q[23], oy_q};
      rz_q <= {in_data_i.vertex_z[23], in_data_i.vertex_z} - {oz_q[23], oz_q};

      prx_q <= rx_q * dx_q;
      pry_q <= ry_q * dy_q;
      prz_q <= rz_q * dz_q;
      sqx_q <= sx[48:0];
      sqy_q <= sy[48:0];
      sqz_q <= sz[48:0];
      ddx_q <= qx[46:0];
      ddy_q <= qy[46:0];
      ddz_q <= qz[46:0];
      rr2_q <= rad_q * rad_q;

      dro_q <= 51'(prx_q) + 51'(pry_q) + 51'(prz_q);
      dd3_q <= 49'(ddx_q) + 49'(ddy_q) + 49'(ddz_q);
      roro_q <= 50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q);
      rr3_q <= rr2_q;

      c_q <= $signed({1'b0, roro_q}) - $signed({5'b0, rr3_q});
      p_q <= dro_q[50] ? 51'(-dro_q) : 51'(dro_q);
      dd4_q <= dd3_q;

      cpos_q <= !c_q[50] && (c_q != '0);
      pll_q <= p_q[25:0] * p_q[25:0];
      plh_q <= p_q[25:0] * p_q[50:26];
      phh_q <= p_q[50:26] * p_q[50:26];
      qll_q <= dd4_q[25:0] * cu[25:0];
      qlh_q <= dd4_q[25:0] * cu[49:26];
      qhl_q <= dd4_q[48:26] * cu[25:0];
      qhh_q <= dd4_q[48:26] * cu[49:26];

      cpos6_q <= cpos_q;
      lhs_q <= (102'(phh_q) << 52) + (102'(plh_q) << 27) + 102'(pll_q);
      rhs_q <= (102'(qhh_q) << 52) + ((102'(qlh_q) + 102'(qhl_q)) << 26)
               + 102'(qll_q);

      hit7_q <= !cpos6_q || (lhs_q >= rhs_q);

      hit8_q <= hit7_q;
    end
  end

  logic [SqrtOutW-1:0] root;

  rsvp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (roro_q),
    .root_o (root)
  );

  logic any_hit;

  assign any_hit = seen_q || hit8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (en && v_q[7]) begin
      seen_q <= last_q[7] ? 1'b0 : any_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.hit <= hit8_q;
      out_data_o.vertex_index <= idx_q[7];
      out_data_o.distance <= 26'(root);
      out_data_o.any_hit <= any_hit;
      out_data_o.pass_end <= last_q[7];
    end
  end

  assign out_valid_o = v_q[8];

endmodule

FILE: rtl/rsvp_checker.sv
// Port-level checks for the vertex ray picker and their binding.
module rsvp_checker import rsvp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input res_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("Output beat changed while stalled.");

  a_any_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |-> out_data_o.any_hit)
    else $error("Hit beat without any_hit.");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("Input stalled while the output is free.");

endmodule

bind ray_sphere_vertex_pick rsvp_checker u_rsvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
